FILE: hw/rtl/lsas_pkg.sv
// shared types and constants for the limit switch arm sequencer
package lsas_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [7:0] duty_t;
    typedef logic [15:0] delay_t;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_SPIN  = 2'd1,
        FUNC_RESET = 2'd2,
        FUNC_STOP  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_STOPPED   = 2'd0,
        MODE_MOVING    = 2'd1,
        MODE_RESETTING = 2'd2,
        MODE_COASTING  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PHASE_NONE     = 2'd0,
        PHASE_APPROACH = 2'd1,
        PHASE_CENTER   = 2'd2
    } phase_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CRUISE_DUTY = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BURST_DUTY  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BURST_MS    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_WAIT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COAST_WAIT  = 3'd4;

    localparam duty_t  CRUISE_DUTY_RESET = 8'd128;
    localparam duty_t  BURST_DUTY_RESET  = 8'd255;
    localparam delay_t BURST_MS_RESET    = 16'd100;
    localparam delay_t CENTER_WAIT_RESET = 16'd200;
    localparam delay_t COAST_WAIT_RESET  = 16'd200;

endpackage

FILE: hw/rtl/lsas_if.sv
// request, result and register write channels of the sequencer
interface lsas_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [31:0] now_ms;
    logic       switch_pressed;

    modport source (output valid, func, now_ms, switch_pressed, input ready);
    modport sink (input valid, func, now_ms, switch_pressed, output ready);
endinterface

interface lsas_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] pin_duty;
    logic [1:0] mode;
    logic [1:0] reset_phase;

    modport source (output valid, pin_duty, mode, reset_phase, input ready);
    modport sink (input valid, pin_duty, mode, reset_phase, output ready);
endinterface

interface lsas_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/limit_switch_arm_sequencer.sv
// top level of the limit switch arm sequencer
// Takes one request per clock while the result side is not stalled and returns one
// result per request, passing through the request register, then the result register.
// All of the work on a request is a short compare and subtract path between those
// registers, so the sustained rate is one request per cycle without result stalls.
// While a finished result waits to be taken, the request register can still take
// one more request; after that the request side stalls.
// Register writes take effect at once and are expected only while the block is idle.
module limit_switch_arm_sequencer (
    input  logic clk,
    input  logic rst_n,
    lsas_cmd_if.sink   cmd,
    lsas_res_if.source res,
    lsas_cfg_if.sink   cfg
);
    import lsas_pkg::*;

    duty_t  cruise_duty_reg;
    duty_t  burst_duty_reg;
    delay_t burst_ms_reg;
    delay_t center_wait_reg;
    delay_t coast_wait_reg;

    logic   in_valid_reg;
    func_t  in_func_reg;
    time_t  in_now_reg;
    logic   in_pressed_reg;

    logic   res_valid_reg;
    duty_t  res_pin_reg;
    mode_t  res_mode_reg;
    phase_t res_phase_reg;

    mode_t  mode_reg, mode_next;
    phase_t phase_reg, phase_next;
    time_t  burst_start_reg, burst_start_next;
    time_t  switch_time_reg, switch_time_next;
    duty_t  drive_level_reg, drive_level_next;
    duty_t  pin_level_reg, pin_level_next;

    logic   advance;
    logic   cmd_take;
    logic   moving;
    time_t  burst_elapsed;
    time_t  switch_elapsed;

    assign advance  = in_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign cmd_take = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign res.valid       = res_valid_reg;
    assign res.pin_duty    = res_pin_reg;
    assign res.mode        = res_mode_reg;
    assign res.reset_phase = res_phase_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_duty_reg <= CRUISE_DUTY_RESET;
            burst_duty_reg  <= BURST_DUTY_RESET;
            burst_ms_reg    <= BURST_MS_RESET;
            center_wait_reg <= CENTER_WAIT_RESET;
            coast_wait_reg  <= COAST_WAIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CRUISE_DUTY: cruise_duty_reg <= cfg.data[7:0];
                CFG_BURST_DUTY:  burst_duty_reg  <= cfg.data[7:0];
                CFG_BURST_MS:    burst_ms_reg    <= cfg.data;
                CFG_CENTER_WAIT: center_wait_reg <= cfg.data;
                CFG_COAST_WAIT:  coast_wait_reg  <= cfg.data;
                default:         ;
            endcase
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_func_reg    <= func_t'(cmd.func);
            in_now_reg     <= time_t'(cmd.now_ms);
            in_pressed_reg <= cmd.switch_pressed;
        end
    end

    // sequencing step for one request
    always_comb
    begin
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        burst_start_next = burst_start_reg;
        switch_time_next = switch_time_reg;
        drive_level_next = drive_level_reg;
        pin_level_next   = pin_level_reg;
        moving           = 1'b0;
        burst_elapsed    = '0;
        switch_elapsed   = '0;

        case (in_func_reg)
            FUNC_SPIN:
            begin
                burst_start_next = in_now_reg;
                drive_level_next = cruise_duty_reg;
                mode_next        = MODE_MOVING;
            end
            FUNC_RESET:
            begin
                burst_start_next = in_now_reg;
                drive_level_next = cruise_duty_reg;
                mode_next        = MODE_RESETTING;
                phase_next       = PHASE_APPROACH;
            end
            FUNC_STOP:
            begin
                drive_level_next = '0;
                mode_next        = MODE_STOPPED;
            end
            default: ;
        endcase

        if (in_func_reg != FUNC_STOP)
        begin
            moving = (mode_next == MODE_MOVING) ||
                     (mode_next == MODE_RESETTING && phase_next == PHASE_APPROACH);
            if (in_pressed_reg && moving)
            begin
                switch_time_next = in_now_reg;
                if (mode_next == MODE_RESETTING)
                begin
                    phase_next = PHASE_CENTER;
                end
                if (mode_next == MODE_MOVING)
                begin
                    mode_next = MODE_COASTING;
                end
            end
            else if (mode_next == MODE_MOVING || mode_next == MODE_RESETTING)
            begin
                burst_elapsed = in_now_reg - burst_start_next;
                if (burst_elapsed < time_t'(burst_ms_reg))
                begin
                    drive_level_next = burst_duty_reg;
                end
                else
                begin
                    drive_level_next = cruise_duty_reg;
                end
                pin_level_next = drive_level_next;
            end
            else
            begin
                pin_level_next = '0;
            end

            switch_elapsed = in_now_reg - switch_time_next;
            if (phase_next == PHASE_CENTER &&
                switch_elapsed > time_t'(center_wait_reg))
            begin
                drive_level_next = '0;
                mode_next        = MODE_STOPPED;
                phase_next       = PHASE_NONE;
            end
            if (mode_next == MODE_COASTING && switch_elapsed > time_t'(coast_wait_reg))
            begin
                drive_level_next = '0;
                mode_next        = MODE_STOPPED;
            end
        end
    end

    // arm state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_STOPPED;
            phase_reg       <= PHASE_NONE;
            burst_start_reg <= '0;
            switch_time_reg <= '0;
            drive_level_reg <= '0;
            pin_level_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            burst_start_reg <= burst_start_next;
            switch_time_reg <= switch_time_next;
            drive_level_reg <= drive_level_next;
            pin_level_reg   <= pin_level_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_pin_reg   <= pin_level_next;
            res_mode_reg  <= mode_next;
            res_phase_reg <= phase_next;
        end
    end

endmodule

FILE: hw/rtl/lsas_checker.sv
// port checks for the limit switch arm sequencer
module lsas_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_pin_duty,
    input logic [1:0] res_mode,
    input logic [1:0] res_reset_phase
);
    import lsas_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       cmd_take;
    logic       res_take;

    assign cmd_take = cmd_valid && cmd_ready;
    assign res_take = res_valid && res_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (cmd_take && !res_take)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (res_take && !cmd_take)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_pin_duty) &&
        $stable(res_mode) && $stable(res_reset_phase))
        else $error("result changed while stalled");

    // no result without a request in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 2'd0)
        else $error("result without request");

    // at most two requests in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many requests in flight");

    // resetting mode always carries an active phase
    a_reset_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_mode == MODE_RESETTING |-> res_reset_phase != PHASE_NONE)
        else $error("resetting without phase");

endmodule

bind limit_switch_arm_sequencer lsas_checker u_lsas_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_pin_duty    (res.pin_duty),
    .res_mode        (res.mode),
    .res_reset_phase (res.reset_phase)
);

FILE: tb/arm_status_pkg.sv
// expected arm status tracking for the limit switch arm sequencer testbench
`timescale 1ns / 100ps

package arm_status_pkg;

    import lsas_pkg::*;

    typedef struct packed {
        duty_t  pin_duty;
        mode_t  mode;
        phase_t reset_phase;
    } arm_status_t;

    class arm_status_board;

        duty_t  cruise_duty;
        duty_t  burst_duty;
        delay_t burst_ms;
        delay_t center_wait;
        delay_t coast_wait;

        mode_t  mode_q;
        phase_t phase_q;
        time_t  burst_start;
        time_t  switch_time;
        duty_t  drive_level;
        duty_t  pin_level;

        arm_status_t expected_status[$];
        int unsigned error_count;

        function new();
            cruise_duty = CRUISE_DUTY_RESET;
            burst_duty  = BURST_DUTY_RESET;
            burst_ms    = BURST_MS_RESET;
            center_wait = CENTER_WAIT_RESET;
            coast_wait  = COAST_WAIT_RESET;
            mode_q      = MODE_STOPPED;
            phase_q     = PHASE_NONE;
            burst_start = '0;
            switch_time = '0;
            drive_level = '0;
            pin_level   = '0;
            error_count = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_BITS-1:0] index,
                                     logic [CFG_DATA_BITS-1:0] data);
            case (index)
                CFG_CRUISE_DUTY: cruise_duty = data[7:0];
                CFG_BURST_DUTY:  burst_duty = data[7:0];
                CFG_BURST_MS:    burst_ms = data;
                CFG_CENTER_WAIT: center_wait = data;
                CFG_COAST_WAIT:  coast_wait = data;
                default:         ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_status.size();
        endfunction

        function void halt_arm();
            drive_level = '0;
            mode_q      = MODE_STOPPED;
        endfunction

        function void run_tick(time_t now, logic pressed);
            logic  moving;
            time_t since_burst;
            time_t since_press;
            moving = (mode_q == MODE_MOVING) ||
                     (mode_q == MODE_RESETTING && phase_q == PHASE_APPROACH);
            if (pressed && moving)
            begin
                switch_time = now;
                if (mode_q == MODE_RESETTING)
                    phase_q = PHASE_CENTER;
                if (mode_q == MODE_MOVING)
                    mode_q = MODE_COASTING;
            end
            else if (mode_q == MODE_MOVING || mode_q == MODE_RESETTING)
            begin
                since_burst = now - burst_start;
                if (since_burst < time_t'(burst_ms))
                    drive_level = burst_duty;
                else
                    drive_level = cruise_duty;
                pin_level = drive_level;
            end
            else
            begin
                pin_level = '0;
            end
            since_press = now - switch_time;
            if (phase_q == PHASE_CENTER && since_press > time_t'(center_wait))
            begin
                halt_arm();
                phase_q = PHASE_NONE;
            end
            if (mode_q == MODE_COASTING && since_press > time_t'(coast_wait))
                halt_arm();
        endfunction

        function void note_request(func_t func, time_t now, logic pressed);
            arm_status_t status;
            case (func)
                FUNC_SPIN:
                begin
                    burst_start = now;
                    drive_level = cruise_duty;
                    mode_q      = MODE_MOVING;
                    run_tick(now, pressed);
                end
                FUNC_RESET:
                begin
                    burst_start = now;
                    mode_q      = MODE_RESETTING;
                    phase_q     = PHASE_APPROACH;
                    drive_level = cruise_duty;
                    run_tick(now, pressed);
                end
                FUNC_STOP:
                    halt_arm();
                default:
                    run_tick(now, pressed);
            endcase
            status.pin_duty    = pin_level;
            status.mode        = mode_q;
            status.reset_phase = phase_q;
            expected_status.push_back(status);
        endfunction

        function void check_status(logic [7:0] pin_duty, logic [1:0] mode,
                                   logic [1:0] reset_phase);
            arm_status_t want;
            if (expected_status.size() == 0)
            begin
                $error("result with no request outstanding: pin_duty %0d mode %0d phase %0d",
                       pin_duty, mode, reset_phase);
                error_count++;
                return;
            end
            want = expected_status.pop_front();
            if (pin_duty !== want.pin_duty)
            begin
                $error("pin_duty: expected %0d, actual %0d", want.pin_duty, pin_duty);
                error_count++;
            end
            if (mode !== want.mode)
            begin
                $error("mode: expected %0d, actual %0d", want.mode, mode);
                error_count++;
            end
            if (reset_phase !== want.reset_phase)
            begin
                $error("reset_phase: expected %0d, actual %0d", want.reset_phase, reset_phase);
                error_count++;
            end
        endfunction

    endclass

endpackage

FILE: tb/testbench.sv
// top level testbench of the limit switch arm sequencer
`timescale 1ns / 100ps

module testbench;

    import lsas_pkg::*;
    import arm_status_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int PHASE_COUNT     = 6;
    localparam int HOLD_LENGTH     = 120;

    logic clk;
    logic rst_n;

    lsas_cmd_if cmd_ch();
    lsas_res_if res_ch();
    lsas_cfg_if cfg_ch();

    arm_status_board board;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          hold_taken;
    int          hold_asked = 0;
    int          cycle_count = 0;
    int unsigned items_sent;

    limit_switch_arm_sequencer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // result side ready, with a long hold-off when requested
    initial
    begin
        res_ch.ready = 1'b0;
        hold_cycles  = 0;
        hold_taken   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_taken)
            begin
                hold_taken  = hold_asked;
                hold_cycles = HOLD_LENGTH;
            end
            if (hold_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            board.note_request(func_t'(cmd_ch.func), cmd_ch.now_ms, cmd_ch.switch_pressed);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_status(res_ch.pin_duty, res_ch.mode, res_ch.reset_phase);
    end

    task automatic send_request(func_t func, time_t now, logic pressed);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.func           <= func;
        cmd_ch.now_ms         <= now;
        cmd_ch.switch_pressed <= pressed;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        board.write_register(index, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_settings(int sel);
        case (sel)
            0:
            begin
                write_register(CFG_CRUISE_DUTY, 16'h0000);
                write_register(CFG_BURST_DUTY, 16'h00FF);
                write_register(CFG_BURST_MS, 16'h0000);
                write_register(CFG_CENTER_WAIT, 16'h0000);
                write_register(CFG_COAST_WAIT, 16'h0000);
            end
            1:
            begin
                write_register(CFG_CRUISE_DUTY, 16'hFFFF);
                write_register(CFG_BURST_DUTY, 16'hFF00);
                write_register(CFG_BURST_MS, 16'hFFFF);
                write_register(CFG_CENTER_WAIT, 16'hFFFF);
                write_register(CFG_COAST_WAIT, 16'hFFFF);
            end
            default:
            begin
                write_register(CFG_CRUISE_DUTY, 16'($urandom_range(0, 65535)));
                write_register(CFG_BURST_DUTY, 16'($urandom_range(0, 65535)));
                write_register(CFG_BURST_MS, 16'($urandom_range(0, 300)));
                write_register(CFG_CENTER_WAIT, 16'($urandom_range(0, 400)));
                write_register(CFG_COAST_WAIT, 16'($urandom_range(0, 400)));
            end
        endcase
        // unused index, must be ignored
        write_register(CFG_COAST_WAIT + 3'($urandom_range(1, 3)), 16'($urandom));
    endtask

    // one spin or reset run with ticks, a possible switch press and a possible stop, or a noise request
    task automatic run_motion();
        int          kind;
        int          steps;
        int          press_at;
        int unsigned longest;
        int unsigned step_max;
        time_t       t;
        logic        pressed;
        func_t       func;
        kind    = $urandom_range(0, 9);
        longest = board.burst_ms;
        if (board.center_wait > longest)
            longest = board.center_wait;
        if (board.coast_wait > longest)
            longest = board.coast_wait;
        step_max = longest / 4 + 2;
        if ($urandom_range(0, 3) == 0)
            t = 32'hFFFF_FFFF - time_t'($urandom_range(0, 4 * step_max));
        else
            t = $urandom;
        if (kind >= 8)
        begin
            send_request(func_t'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
            return;
        end
        func = (kind >= 4 && kind <= 6) ? FUNC_RESET : FUNC_SPIN;
        send_request(func, t, $urandom_range(0, 7) == 0);
        steps    = $urandom_range(3, 12);
        press_at = $urandom_range(0, steps);
        pressed  = 1'b0;
        for (int k = 0; k < steps; k++)
        begin
            t = t + time_t'($urandom_range(0, step_max));
            if (k == press_at)
                pressed = 1'b1;
            else if (pressed && $urandom_range(0, 3) == 0)
                pressed = 1'b0;
            func = (kind == 7 && k == steps / 2) ? FUNC_STOP : FUNC_TICK;
            send_request(func, t, pressed);
        end
    endtask

    initial
    begin
        int          phase;
        int unsigned phase_start;
        bit          paused;
        board                 = new();
        rst_n                 = 1'b0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.func           = FUNC_TICK;
        cmd_ch.now_ms         = '0;
        cmd_ch.switch_pressed = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_CRUISE_DUTY;
        cfg_ch.data           = '0;
        send_idle_pct         = 21;
        recv_idle_pct         = 50;
        items_sent            = 0;
        paused                = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stopped ticks
        send_request(FUNC_TICK, 32'd0, 1'b0);
        send_request(FUNC_TICK, 32'd10, 1'b1);
        // burst edge, press while moving, coast delay edge
        send_request(FUNC_SPIN, 32'd1000, 1'b0);
        send_request(FUNC_TICK, 32'd1099, 1'b0);
        send_request(FUNC_TICK, 32'd1100, 1'b0);
        send_request(FUNC_TICK, 32'd1150, 1'b1);
        send_request(FUNC_TICK, 32'd1350, 1'b1);
        send_request(FUNC_TICK, 32'd1351, 1'b0);
        // spin with the switch already pressed
        send_request(FUNC_SPIN, 32'd2000, 1'b1);
        send_request(FUNC_TICK, 32'd2300, 1'b0);
        // reset across the timestamp wrap, centering delay edge
        send_request(FUNC_RESET, 32'hFFFF_FFC0, 1'b0);
        send_request(FUNC_TICK, 32'h0000_0010, 1'b0);
        send_request(FUNC_TICK, 32'h0000_0030, 1'b0);
        send_request(FUNC_TICK, 32'h0000_0040, 1'b1);
        send_request(FUNC_TICK, 32'h0000_0108, 1'b0);
        send_request(FUNC_TICK, 32'h0000_0109, 1'b0);
        // stop keeps the centering phase
        send_request(FUNC_RESET, 32'd5000, 1'b1);
        send_request(FUNC_STOP, 32'd5001, 1'b0);
        send_request(FUNC_TICK, 32'd5300, 1'b0);
        // stop holds the pin until the next tick
        send_request(FUNC_SPIN, 32'd6000, 1'b0);
        send_request(FUNC_STOP, 32'd6010, 1'b1);
        send_request(FUNC_TICK, 32'd6020, 1'b0);
        send_request(FUNC_TICK, 32'hFFFF_FFFF, 1'b1);
        send_request(FUNC_STOP, 32'hFFFF_FFFF, 1'b1);

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase == 2)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 21;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            load_settings(phase == 1 ? 0 : (phase == 3 ? 1 : 2));
            if (phase == 4)
                hold_asked++;
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                run_motion();
                if (phase == 3 && !paused && items_sent - phase_start >= 50)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (board.error_count == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
